[src/aabb_pkg.sv]
// Shared types and widths for the box pair collision detector.
package aabb_pkg;
	localparam int unsigned CoordW = 24;
	localparam int unsigned SizeW = 23;
	localparam int unsigned MarginW = 16;
	localparam int unsigned WideW = 29;
	localparam int unsigned ContactW = 27;
	localparam int unsigned FixW = 28;
	localparam int unsigned IdxW = 3;

	typedef logic signed [WideW-1:0] wide_t;

	typedef struct packed {
		logic signed [ContactW-1:0] contact_x;
		logic signed [ContactW-1:0] contact_y;
		logic signed [FixW-1:0] fix_x;
		logic signed [FixW-1:0] fix_y;
	} pair_res_t;
endpackage

[src/aabb_pair_unit.sv]
// Shared add/compare unit that tests one box pair over several steps.
module aabb_pair_unit import aabb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  logic signed [CoordW-1:0] ax_c,
	input  logic signed [CoordW-1:0] ay_c,
	input  logic [SizeW-1:0] ahx,
	input  logic [SizeW-1:0] ahy,
	input  logic signed [CoordW-1:0] bx_c,
	input  logic signed [CoordW-1:0] by_c,
	input  logic [SizeW-1:0] bhx,
	input  logic [SizeW-1:0] bhy,
	input  logic [MarginW-1:0] margin,
	output logic done,
	output logic hit,
	output pair_res_t res
);
	typedef enum logic [2:0] {S_IDLE, S_SEP_X, S_SEP_Y, S_OVL, S_OUT} ustate_t;
	ustate_t state_q;
	logic hit_q;
	wide_t dx_q, dy_q, ox_q;
	wide_t ax, ay, bx, by, hax, hay, hbx, hby, m;
	wide_t op_a, op_b, sum;
	wide_t adx, ady, oy;
	logic zero;

	always_comb begin
		ax = wide_t'($signed({ax_c, 1'b0}));
		ay = wide_t'($signed({ay_c, 1'b0}));
		bx = wide_t'($signed({bx_c, 1'b0}));
		by = wide_t'($signed({by_c, 1'b0}));
		hax = wide_t'({1'b0, ahx});
		hay = wide_t'({1'b0, ahy});
		hbx = wide_t'({1'b0, bhx});
		hby = wide_t'({1'b0, bhy});
		m = wide_t'({1'b0, margin, 1'b0});
		zero = (ahx == '0) || (ahy == '0) || (bhx == '0) || (bhy == '0);
		// shared difference unit: center distance per axis
		op_a = (state_q == S_SEP_Y) ? ay : ax;
		op_b = (state_q == S_SEP_Y) ? by : bx;
		sum = op_a - op_b;
		adx = dx_q[WideW-1] ? -dx_q : dx_q;
		ady = dy_q[WideW-1] ? -dy_q : dy_q;
		oy = hay + hby - ady;
	end

	// separation on an axis with distance d: |d| >= ha+hb-m
	function automatic logic sep(wide_t d, wide_t ha, wide_t hb, wide_t mm);
		wide_t s;
		s = ha + hb - mm;
		return (d >= s) || (-d >= s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hit_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (go) begin
					hit_q <= !zero;
					state_q <= S_SEP_X;
				end
				S_SEP_X: begin
					dx_q <= sum;
					if (sep(sum, hax, hbx, m)) hit_q <= 1'b0;
					state_q <= S_SEP_Y;
				end
				S_SEP_Y: begin
					dy_q <= sum;
					if (sep(sum, hay, hby, m)) hit_q <= 1'b0;
					state_q <= S_OVL;
				end
				S_OVL: begin
					ox_q <= hax + hbx - adx;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (ox_q < oy) begin
						res.contact_x <= ContactW'(dx_q > 0 ? ax - hax : ax + hax);
						res.contact_y <= ContactW'(by);
						res.fix_x <= FixW'(dx_q > 0 ? (bx + hbx) - (ax - hax)
							: (bx - hbx) - (ax + hax));
						res.fix_y <= '0;
					end else begin
						res.contact_x <= ContactW'(bx);
						res.contact_y <= ContactW'(dy_q > 0 ? ay - hay : ay + hay);
						res.fix_x <= '0;
						res.fix_y <= FixW'(dy_q > 0 ? (by + hby) - (ay - hay)
							: (by - hby) - (ay + hay));
					end
					hit <= hit_q;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[src/aabb_pair_collision_detect.sv]
// A box that is not last is stored when it is taken; busy stays low.
// A last box starts a scan of every pair i<j: a skipped pair costs a pick step,
// a tested pair a pick and then a run on the shared add/compare unit.
// A hit is on the outputs the cycle after its test ends; the end record is
// registered from the end state that follows the scan.
// The receiver cannot stall results. Reset clears the box count, sequencer and margin.
module aabb_pair_collision_detect import aabb_pkg::*; #(
	parameter int unsigned MAX_BOXES = 8,
	parameter int unsigned LAYER_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic start,
	output logic busy,
	input  logic signed [CoordW-1:0] center_x,
	input  logic signed [CoordW-1:0] center_y,
	input  logic [SizeW-1:0] size_x,
	input  logic [SizeW-1:0] size_y,
	input  logic [15:0] layer_mask,
	input  logic [15:0] ignore_mask,
	input  logic active,
	input  logic last_box,
	output logic strobe,
	output logic pair_valid,
	output logic [IdxW-1:0] first_index,
	output logic [IdxW-1:0] second_index,
	output logic signed [ContactW-1:0] contact_x,
	output logic signed [ContactW-1:0] contact_y,
	output logic signed [FixW-1:0] fix_x,
	output logic signed [FixW-1:0] fix_y,
	output logic last
);
	localparam int unsigned AW = $clog2(MAX_BOXES);
	localparam int unsigned CW = $clog2(MAX_BOXES + 1);
	localparam int unsigned LW = (LAYER_BITS < 16) ? LAYER_BITS : 16;

	typedef enum logic [1:0] {T_IDLE, T_PICK, T_WAIT, T_END} tstate_t;

	logic signed [CoordW-1:0] cx_mem [MAX_BOXES];
	logic signed [CoordW-1:0] cy_mem [MAX_BOXES];
	logic [SizeW-1:0] sx_mem [MAX_BOXES];
	logic [SizeW-1:0] sy_mem [MAX_BOXES];
	logic [LW-1:0] lay_mem [MAX_BOXES];
	logic [LW-1:0] ign_mem [MAX_BOXES];
	logic [MAX_BOXES-1:0] act_q;
	logic [CW-1:0] count_q;
	logic [MarginW-1:0] margin_q;
	tstate_t state_q;
	logic [AW-1:0] i_q, j_q;
	logic go_q, done, hit;
	pair_res_t res;
	logic take, eligible, j_end, i_end;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, margin_q} : 32'd0;
	assign busy = (state_q != T_IDLE);
	assign take = start && !busy;
	assign eligible = act_q[i_q] && act_q[j_q]
		&& ((ign_mem[i_q] & lay_mem[j_q]) == '0)
		&& ((ign_mem[j_q] & lay_mem[i_q]) == '0);
	assign j_end = ({1'b0, j_q} + 1'b1) >= (AW+1)'(count_q);
	assign i_end = ({1'b0, i_q} + 2'd2) >= (AW+1)'(count_q);

	always_ff @(posedge clk) begin
		if (take && count_q < CW'(MAX_BOXES)) begin
			cx_mem[count_q[AW-1:0]] <= center_x;
			cy_mem[count_q[AW-1:0]] <= center_y;
			sx_mem[count_q[AW-1:0]] <= size_x;
			sy_mem[count_q[AW-1:0]] <= size_y;
			lay_mem[count_q[AW-1:0]] <= layer_mask[LW-1:0];
			ign_mem[count_q[AW-1:0]] <= ignore_mask[LW-1:0];
			act_q[count_q[AW-1:0]] <= active;
		end
	end

	aabb_pair_unit u_pair (
		.clk(clk), .arst_n(arst_n), .go(go_q),
		.ax_c(cx_mem[i_q]), .ay_c(cy_mem[i_q]), .ahx(sx_mem[i_q]), .ahy(sy_mem[i_q]),
		.bx_c(cx_mem[j_q]), .by_c(cy_mem[j_q]), .bhx(sx_mem[j_q]), .bhy(sy_mem[j_q]),
		.margin(margin_q), .done(done), .hit(hit), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			count_q <= '0;
			margin_q <= '0;
			go_q <= 1'b0;
			strobe <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			strobe <= 1'b0;
			go_q <= 1'b0;
			if (psel && penable && pwrite && paddr == 2'd0) margin_q <= pwdata[MarginW-1:0];
			case (state_q)
				T_IDLE: if (take) begin
					if (count_q < CW'(MAX_BOXES)) count_q <= count_q + 1'b1;
					if (last_box) begin
						i_q <= '0;
						j_q <= AW'(1);
						if (count_q < CW'(MAX_BOXES) && count_q != '0) state_q <= T_PICK;
						else if (count_q >= CW'(2)) state_q <= T_PICK;
						else state_q <= T_END;
					end
				end
				T_PICK: begin
					if (eligible) begin
						go_q <= 1'b1;
						state_q <= T_WAIT;
					end else if (!j_end) j_q <= j_q + 1'b1;
					else if (!i_end) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + AW'(2);
					end else state_q <= T_END;
				end
				T_WAIT: if (done) begin
					if (hit) begin
						strobe <= 1'b1;
						pair_valid <= 1'b1;
						last <= 1'b0;
						first_index <= IdxW'(i_q);
						second_index <= IdxW'(j_q);
						contact_x <= res.contact_x;
						contact_y <= res.contact_y;
						fix_x <= res.fix_x;
						fix_y <= res.fix_y;
					end
					if (!j_end) begin
						j_q <= j_q + 1'b1;
						state_q <= T_PICK;
					end else if (!i_end) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + AW'(2);
						state_q <= T_PICK;
					end else state_q <= T_END;
				end
				T_END: begin
					strobe <= 1'b1;
					pair_valid <= 1'b0;
					last <= 1'b1;
					first_index <= '0;
					second_index <= '0;
					contact_x <= '0;
					contact_y <= '0;
					fix_x <= '0;
					fix_y <= '0;
					count_q <= '0;
					state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_BOXES)) else $error("box count overflow");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_END) |=> (strobe && last && count_q == '0))
		else $error("end record missing");
	a_go: assert property (@(posedge clk) disable iff (!arst_n)
		go_q |-> (state_q == T_WAIT)) else $error("pair start outside wait");
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the box pair collision detector.
module tb;
	import aabb_pkg::*;

	localparam int NBOX = 8;
	localparam int WDOG_LIMIT = 20000;
	localparam logic [1:0] ADDR_MARGIN = 2'd0;

	typedef struct {
		logic signed [CoordW-1:0] cx;
		logic signed [CoordW-1:0] cy;
		logic [SizeW-1:0] sx;
		logic [SizeW-1:0] sy;
		logic [15:0] layer;
		logic [15:0] ignore;
		logic act;
		logic lastb;
	} box_req_t;

	typedef struct {
		logic valid;
		logic [IdxW-1:0] ia;
		logic [IdxW-1:0] ib;
		logic signed [ContactW-1:0] kx;
		logic signed [ContactW-1:0] ky;
		logic signed [FixW-1:0] fx;
		logic signed [FixW-1:0] fy;
		logic endrec;
	} contact_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 0;
	logic busy;
	logic signed [CoordW-1:0] center_x = '0, center_y = '0;
	logic [SizeW-1:0] size_x = '0, size_y = '0;
	logic [15:0] layer_mask = '0, ignore_mask = '0;
	logic active = 0, last_box = 0;
	logic strobe, pair_valid, last;
	logic [IdxW-1:0] first_index, second_index;
	logic signed [ContactW-1:0] contact_x, contact_y;
	logic signed [FixW-1:0] fix_x, fix_y;

	aabb_pair_collision_detect dut (.*);

	always #2 clk = ~clk;

	// predictor state
	box_req_t frame_boxes[NBOX];
	int frame_count = 0;
	logic [15:0] margin_q = '0;
	contact_t expected_contacts[$];
	int failures = 0;
	int idle_cycles = 0;

	function automatic void predict_box(box_req_t b);
		longint m, ax, ay, bx, by, ahx, ahy, bhx, bhy;
		longint al, ar, at, ab, bl, br, bt, bb, dx, dy, ox, oy;
		longint kx, ky, fx, fy;
		contact_t c;
		if (frame_count < NBOX) begin
			frame_boxes[frame_count] = b;
			frame_count++;
		end
		if (!b.lastb)
			return;
		m = 2 * longint'(margin_q);
		for (int i = 0; i < frame_count; i++) begin
			if (!frame_boxes[i].act)
				continue;
			for (int j = i + 1; j < frame_count; j++) begin
				if (!frame_boxes[j].act)
					continue;
				if ((frame_boxes[i].ignore & frame_boxes[j].layer) != 0 ||
				    (frame_boxes[j].ignore & frame_boxes[i].layer) != 0)
					continue;
				ax = 2 * longint'(frame_boxes[i].cx);
				ay = 2 * longint'(frame_boxes[i].cy);
				bx = 2 * longint'(frame_boxes[j].cx);
				by = 2 * longint'(frame_boxes[j].cy);
				ahx = frame_boxes[i].sx; ahy = frame_boxes[i].sy;
				bhx = frame_boxes[j].sx; bhy = frame_boxes[j].sy;
				if (ahx == 0 || ahy == 0 || bhx == 0 || bhy == 0)
					continue;
				al = ax - ahx; ar = ax + ahx; at = ay + ahy; ab = ay - ahy;
				bl = bx - bhx; br = bx + bhx; bt = by + bhy; bb = by - bhy;
				if (al >= br - m || bl >= ar - m || ab >= bt - m || bb >= at - m)
					continue;
				dx = ax - bx;
				dy = ay - by;
				ox = ahx + bhx - (dx < 0 ? -dx : dx);
				oy = ahy + bhy - (dy < 0 ? -dy : dy);
				if (ox < oy) begin
					kx = dx > 0 ? al : ar;
					ky = by;
					fx = (dx > 0 ? br : bl) - kx;
					fy = 0;
				end else begin
					kx = bx;
					ky = dy > 0 ? ab : at;
					fx = 0;
					fy = (dy > 0 ? bt : bb) - ky;
				end
				c = '{1'b1, i[IdxW-1:0], j[IdxW-1:0], kx[ContactW-1:0],
					ky[ContactW-1:0], fx[FixW-1:0], fy[FixW-1:0], 1'b0};
				expected_contacts.insert(expected_contacts.size(), c);
			end
		end
		c = '{1'b0, '0, '0, '0, '0, '0, '0, 1'b1};
		expected_contacts.insert(expected_contacts.size(), c);
		frame_count = 0;
	endfunction

	// check every result against the oldest expectation
	always @(posedge clk) begin
		contact_t e;
		if (arst_n && strobe) begin
			if (expected_contacts.size() == 0) begin
				$error("unexpected result");
				failures++;
			end else begin
				e = expected_contacts.pop_front();
				if (pair_valid !== e.valid) begin
					$error("pair_valid exp %0d got %0d", e.valid, pair_valid); failures++;
				end
				if (first_index !== e.ia) begin
					$error("first_index exp %0d got %0d", e.ia, first_index); failures++;
				end
				if (second_index !== e.ib) begin
					$error("second_index exp %0d got %0d", e.ib, second_index); failures++;
				end
				if (contact_x !== e.kx) begin
					$error("contact_x exp %0d got %0d", e.kx, contact_x); failures++;
				end
				if (contact_y !== e.ky) begin
					$error("contact_y exp %0d got %0d", e.ky, contact_y); failures++;
				end
				if (fix_x !== e.fx) begin
					$error("fix_x exp %0d got %0d", e.fx, fix_x); failures++;
				end
				if (fix_y !== e.fy) begin
					$error("fix_y exp %0d got %0d", e.fy, fix_y); failures++;
				end
				if (last !== e.endrec) begin
					$error("last exp %0d got %0d", e.endrec, last); failures++;
				end
			end
		end
	end

	// watchdog: count cycles with no accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || strobe || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_margin(input logic [15:0] value);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= ADDR_MARGIN; pwdata <= {16'd0, value};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		margin_q = value;
	endtask

	task automatic drain();
		while (expected_contacts.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send_box(input box_req_t b, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		@(negedge clk);
		if (gap != 0) begin
			start <= 0;
			repeat (gap - 1) @(negedge clk);
			@(negedge clk);
		end
		start <= 1;
		center_x <= b.cx; center_y <= b.cy; size_x <= b.sx; size_y <= b.sy;
		layer_mask <= b.layer; ignore_mask <= b.ignore;
		active <= b.act; last_box <= b.lastb;
		do @(posedge clk); while (busy);
		predict_box(b);
		@(negedge clk);
		start <= 0;
	endtask

	function automatic box_req_t rand_box(input bit lastb);
		box_req_t b;
		int mode;
		mode = $urandom_range(0, 9);
		b.cx = (mode == 0) ? CoordW'($urandom) : CoordW'($signed($urandom_range(0, 4095)) - 2048);
		b.cy = (mode == 1) ? CoordW'($urandom) : CoordW'($signed($urandom_range(0, 4095)) - 2048);
		b.sx = (mode == 2) ? SizeW'($urandom) : SizeW'($urandom_range(0, 1500));
		b.sy = (mode == 3) ? SizeW'($urandom) : SizeW'($urandom_range(0, 1500));
		if ($urandom_range(0, 2) == 0) begin
			b.layer = 16'($urandom);
			b.ignore = 16'($urandom);
		end else begin
			b.layer = 16'(1 << $urandom_range(0, 15));
			b.ignore = ($urandom_range(0, 3) == 0) ? 16'(1 << $urandom_range(0, 15)) : 16'd0;
		end
		b.act = ($urandom_range(0, 7) != 0);
		b.lastb = lastb;
		return b;
	endfunction

	// directed stimulus: three frames, full store plus overflow, ties, zero sizes
	box_req_t directed[] = '{
		'{24'sd0, 24'sd0, 23'd0, 23'd256, 16'h1, 16'h0, 1'b1, 1'b1},
		'{24'sd0, 24'sd0, 23'd512, 23'd512, 16'h1, 16'h0, 1'b1, 1'b0},
		'{24'sd0, 24'sd0, 23'd512, 23'd512, 16'h1, 16'h0, 1'b1, 1'b0},
		'{24'sd100, 24'sd0, 23'd512, 23'd512, 16'h2, 16'h0, 1'b1, 1'b0},
		'{24'sd0, -24'sd100, 23'd512, 23'd800, 16'h4, 16'h0, 1'b1, 1'b0},
		'{24'sd50, 24'sd50, 23'd400, 23'd400, 16'h8, 16'h1, 1'b1, 1'b0},
		'{24'sd30, 24'sd30, 23'd300, 23'd300, 16'hFFFF, 16'h0, 1'b0, 1'b0},
		'{-24'sd8388608, -24'sd8388608, 23'd8388607, 23'd8388607, 16'h0, 16'h0, 1'b1, 1'b0},
		'{24'sd8388607, 24'sd8388607, 23'd8388607, 23'd8388607, 16'h0, 16'hFFFF, 1'b1, 1'b0},
		'{24'sd1, 24'sd1, 23'd1, 23'd1, 16'h1, 16'h0, 1'b1, 1'b1},
		'{-24'sd8388608, 24'sd8388607, 23'd8388607, 23'd1, 16'h8000, 16'h0, 1'b1, 1'b0},
		'{24'sd8388607, -24'sd8388608, 23'd1, 23'd8388607, 16'h8000, 16'h0, 1'b1, 1'b0},
		'{24'sd10, 24'sd10, 23'd200, 23'd200, 16'h1, 16'h0, 1'b1, 1'b1}
	};

	initial begin
		box_req_t b;
		int nbox;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		foreach (directed[k])
			send_box(directed[k], 1'b0);
		drain();
		write_margin(16'hFFFF);
		foreach (directed[k])
			send_box(directed[k], 1'b1);
		drain();
		write_margin(16'd0);
		for (int f = 0; f < 30; f++) begin
			if (f == 13) begin
				drain();
				write_margin(16'($urandom_range(0, 600)));
			end
			if (f == 27) begin
				drain();
				write_margin(16'($urandom));
			end
			nbox = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 10) : $urandom_range(2, 8);
			for (int k = 0; k < nbox; k++) begin
				b = rand_box(k == nbox - 1);
				send_box(b, f % 4 != 0);
			end
		end
		drain();
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
